// File: src/lge_pkg.sv
package lge_pkg;

    localparam int GRID_W_DEF = 64;
    localparam int GRID_H_DEF = 64;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int COUNT_W = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             write_value;
    } req_t;

    typedef struct packed {
        logic               cell_value;
        logic [COUNT_W-1:0] changed_count;
    } rsp_t;

endpackage

// File: src/life_grid_generation_engine.sv
// B3/S23 life engine on a GRID_W by GRID_H grid, held as one row per word in a
// row memory with one read and one write port; the outer frame of cells is
// always dead and the grid reads as all dead after reset, with no clearing pass,
// since each row carries a valid flag. An interior cell write or an in-grid cell
// read passes from acceptance to result through accept with row read, modify and
// write back (or take the cell), then result; a request that touches no row goes
// straight to the result. A generation step sweeps the interior rows: it evaluates
// one interior cell per cycle through a single neighbour-count unit, with a state
// per row to fetch the row below and one to write the updated row back. The
// result reports the cell read and, for a step, the number of cells that changed,
// saturating at 4095. A new transaction is taken as soon as the previous result
// sits in the output register, even if that result has not yet been collected.
module life_grid_generation_engine
    import lge_pkg::*;
#(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CW = $clog2(GRID_W);
    localparam int RW = $clog2(GRID_H);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_LOAD0,
        S_LOAD1,
        S_LOADB,
        S_CELL,
        S_WRROW,
        S_RESP
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [RW-1:0]      row_cnt_reg, row_cnt_next;
    logic [CW-1:0]      col_cnt_reg, col_cnt_next;
    logic [GRID_W-1:0]  prior0_reg, prior0_next;
    logic [GRID_W-1:0]  prior1_reg, prior1_next;
    logic [GRID_W-1:0]  below_reg, below_next;
    logic [GRID_W-1:0]  new_row_reg, new_row_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               cell_reg, cell_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic              mem_rd_en;
    logic [RW-1:0]     mem_rd_addr;
    logic              mem_wr_en;
    logic [RW-1:0]     mem_wr_addr;
    logic [GRID_W-1:0] mem_wr_data;
    logic [GRID_W-1:0] mem_rd_data;

    logic              rule_next;
    logic              rule_changed;
    logic              req_in_grid;
    logic              req_interior;
    logic [CW-1:0]     req_col_idx;
    logic [GRID_W-1:0] patched_row;

    lge_row_mem #(
        .DEPTH (GRID_H),
        .WIDTH (GRID_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    lge_cell_rule #(
        .WIDTH (GRID_W)
    ) u_cell_rule (
        .above_row (prior0_reg),
        .cur_row   (prior1_reg),
        .below_row (below_reg),
        .col       (col_cnt_reg),
        .next_cell (rule_next),
        .changed   (rule_changed)
    );

    always_comb
    begin
        req_in_grid  = (int'(req.col) < GRID_W) && (int'(req.row) < GRID_H);
        req_interior = (req.col != '0) && (int'(req.col) + 1 < GRID_W)
                    && (req.row != '0) && (int'(req.row) + 1 < GRID_H);
        req_col_idx  = CW'(req_reg.col);
        patched_row  = mem_rd_data;
        patched_row[req_col_idx] = req_reg.write_value;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        prior0_next    = prior0_reg;
        prior1_next    = prior1_reg;
        below_next     = below_reg;
        new_row_next   = new_row_reg;
        count_next     = count_reg;
        cell_next      = cell_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = RW'(req.row);
        mem_wr_en      = 1'b0;
        mem_wr_addr    = row_cnt_reg;
        mem_wr_data    = new_row_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    count_next = '0;
                    cell_next  = 1'b0;
                    case (req.req_type)
                        REQ_WRITE:
                        begin
                            if (req_interior)
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        REQ_READ:
                        begin
                            if (req_in_grid)
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        REQ_STEP:
                        begin
                            mem_rd_en    = 1'b1;
                            mem_rd_addr  = '0;
                            row_cnt_next = RW'(1);
                            state_next   = S_LOAD0;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                if (req_reg.req_type == REQ_WRITE)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = RW'(req_reg.row);
                    mem_wr_data = patched_row;
                end
                else
                begin
                    cell_next = mem_rd_data[req_col_idx];
                end
                state_next = S_RESP;
            end
            S_LOAD0:
            begin
                prior0_next = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = row_cnt_reg;
                state_next  = S_LOAD1;
            end
            S_LOAD1:
            begin
                prior1_next = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = RW'(row_cnt_reg + 1'b1);
                state_next  = S_LOADB;
            end
            S_LOADB:
            begin
                below_next   = mem_rd_data;
                new_row_next = prior1_reg;
                col_cnt_next = CW'(1);
                state_next   = S_CELL;
            end
            S_CELL:
            begin
                new_row_next[col_cnt_reg] = rule_next;
                if (rule_changed && (count_reg != COUNT_MAX))
                begin
                    count_next = count_reg + 1'b1;
                end
                col_cnt_next = col_cnt_reg + 1'b1;
                if (col_cnt_reg == CW'(GRID_W - 2))
                begin
                    state_next = S_WRROW;
                end
            end
            S_WRROW:
            begin
                // The row below has already been fetched, so writing this row
                // back cannot disturb any neighbour still to be evaluated.
                mem_wr_en   = 1'b1;
                prior0_next = prior1_reg;
                prior1_next = below_reg;
                if (row_cnt_reg == RW'(GRID_H - 2))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = RW'(int'(row_cnt_reg) + 2);
                    row_cnt_next = row_cnt_reg + 1'b1;
                    state_next   = S_LOADB;
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.cell_value    = cell_reg;
                    rsp_next.changed_count = count_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        row_cnt_reg <= row_cnt_next;
        col_cnt_reg <= col_cnt_next;
        prior0_reg  <= prior0_next;
        prior1_reg  <= prior1_next;
        below_reg   <= below_next;
        new_row_reg <= new_row_next;
        count_reg   <= count_next;
        cell_reg    <= cell_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_frame_row_write : assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (mem_wr_addr != '0) && (int'(mem_wr_addr) != GRID_H - 1))
        else $error("row write targets a frame row");

    a_write_only_when_due : assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_RD_WAIT) || (state_reg == S_WRROW))
        else $error("row write outside a write-back cycle");

    a_sweep_column_interior : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CELL) |-> (col_cnt_reg != '0) && (int'(col_cnt_reg) <= GRID_W - 2))
        else $error("sweep column left the interior");

    a_result_fields_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.changed_count != '0) |-> !rsp.cell_value)
        else $error("result carries both a cell value and a change count");

endmodule

// File: src/lge_row_mem.sv
module lge_row_mem
    import lge_pkg::*;
#(
    parameter int DEPTH = GRID_H_DEF,
    parameter int WIDTH = GRID_W_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] row_mem [DEPTH];
    logic [WIDTH-1:0] data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= row_mem[rd_addr];
        end
    end

    // A row that has never been written since reset reads as all dead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? data_reg : '0;

endmodule

// File: src/lge_cell_rule.sv
module lge_cell_rule
    import lge_pkg::*;
#(
    parameter int WIDTH = GRID_W_DEF,
    localparam int CW = $clog2(WIDTH)
)
(
    input  logic [WIDTH-1:0] above_row,
    input  logic [WIDTH-1:0] cur_row,
    input  logic [WIDTH-1:0] below_row,
    input  logic [CW-1:0]    col,
    output logic             next_cell,
    output logic             changed
);

    logic [CW-1:0] col_l;
    logic [CW-1:0] col_r;
    logic [3:0]    neighbours;

    always_comb
    begin
        col_l = col - 1'b1;
        col_r = col + 1'b1;
        neighbours = 4'(above_row[col_l]) + 4'(above_row[col]) + 4'(above_row[col_r])
                   + 4'(cur_row[col_l]) + 4'(cur_row[col_r])
                   + 4'(below_row[col_l]) + 4'(below_row[col]) + 4'(below_row[col_r]);
        if (cur_row[col])
        begin
            next_cell = (neighbours == 4'd2) || (neighbours == 4'd3);
        end
        else
        begin
            next_cell = (neighbours == 4'd3);
        end
        changed = next_cell ^ cur_row[col];
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import lge_pkg::*;

    localparam int GRID_W = GRID_W_DEF;
    localparam int GRID_H = GRID_H_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;

    // Mirror of the cell grid; it predicts the response to every accepted request.
    class life_grid_tracker;
        bit   alive [GRID_H][GRID_W];
        rsp_t expected_rsps [$];
        int   errors;
        int   n_write;
        int   n_read;
        int   n_step;
        int   n_busy_step;
        int   n_unused;
        int   n_checked;

        function int next_generation();
            bit prev [GRID_H][GRID_W];
            int changes;
            prev = alive;
            changes = 0;
            for (int r = 1; r < GRID_H - 1; r++) begin
                for (int c = 1; c < GRID_W - 1; c++) begin
                    int  n;
                    bit  nxt;
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0)
                                n += prev[r + dr][c + dc];
                        end
                    end
                    nxt = prev[r][c] ? (n == 2 || n == 3) : (n == 3);
                    if (nxt != prev[r][c])
                        changes++;
                    alive[r][c] = nxt;
                end
            end
            return (changes > COUNT_MAX) ? int'(COUNT_MAX) : changes;
        endfunction

        function void note_request(req_t q);
            rsp_t want;
            want = '0;
            case (req_type_t'(q.req_type))
                REQ_WRITE:
                begin
                    n_write++;
                    // Frame cells are never written, so the frame stays dead.
                    if (q.col >= 1 && q.col < GRID_W - 1 && q.row >= 1 && q.row < GRID_H - 1)
                        alive[q.row][q.col] = q.write_value;
                end
                REQ_READ:
                begin
                    n_read++;
                    if (q.col < GRID_W && q.row < GRID_H)
                        want.cell_value = alive[q.row][q.col];
                end
                REQ_STEP:
                begin
                    n_step++;
                    want.changed_count = COUNT_W'(next_generation());
                    if (want.changed_count != 0)
                        n_busy_step++;
                end
                default:
                begin
                    n_unused++;
                end
            endcase
            expected_rsps.push_back(want);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%0t: response with none outstanding: cell_value %0b changed_count %0d",
                         $time, got.cell_value, got.changed_count);
                return;
            end
            want = expected_rsps.pop_front();
            n_checked++;
            if (got.cell_value !== want.cell_value) begin
                errors++;
                $display("%0t: cell_value expected %0b, got %0b",
                         $time, want.cell_value, got.cell_value);
            end
            if (got.changed_count !== want.changed_count) begin
                errors++;
                $display("%0t: changed_count expected %0d, got %0d",
                         $time, want.changed_count, got.changed_count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    life_grid_tracker grid = new;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit hold_off_start = 1'b0;

    life_grid_generation_engine uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Response monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            grid.check_response(rsp);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("life_grid_generation_engine: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_off_start) begin
                hold_left = HOLD_CYCLES;
                hold_off_start = 1'b0;
            end
            if (hold_left > 0) begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else begin
                rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
            end
        end
    end

    function automatic req_t make_req(req_type_t kind, int c, int r, bit v);
        req_t q;
        q.req_type    = kind;
        q.col         = c[COL_W-1:0];
        q.row         = r[ROW_W-1:0];
        q.write_value = v;
        return q;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(req_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        grid.note_request(item);
        items_sent++;
        @(negedge clk);
    endtask

    // Mostly small live patterns followed by generations and read-back,
    // mixed with stray requests of any kind anywhere in the grid.
    task automatic random_phase(int count);
        int target;
        int ocol;
        int orow;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 70) begin
                ocol = $urandom_range(0, GRID_W - 6);
                orow = $urandom_range(0, GRID_H - 6);
                repeat ($urandom_range(4, 10))
                    send_item(make_req(REQ_WRITE, ocol + $urandom_range(0, 5),
                                       orow + $urandom_range(0, 5),
                                       $urandom_range(99) < 75));
                repeat ($urandom_range(1, 2))
                    send_item(make_req(REQ_STEP, $urandom_range(0, 63),
                                       $urandom_range(0, 63), $urandom_range(0, 1)));
                repeat ($urandom_range(2, 4))
                    send_item(make_req(REQ_READ, ocol + $urandom_range(0, 5),
                                       orow + $urandom_range(0, 5), $urandom_range(0, 1)));
            end
            else begin
                send_item(make_req(req_type_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                                   $urandom_range(0, 63), $urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: frame and corner cells, unused code, a blinker.
        send_item(make_req(REQ_READ, 0, 0, 1'b1));
        send_item(make_req(REQ_READ, 63, 63, 1'b0));
        send_item(make_req(REQ_WRITE, 0, 0, 1'b1));
        send_item(make_req(REQ_WRITE, 63, 63, 1'b1));
        send_item(make_req(REQ_WRITE, 0, 30, 1'b1));
        send_item(make_req(REQ_WRITE, 30, 63, 1'b1));
        send_item(make_req(REQ_READ, 0, 0, 1'b0));
        send_item(make_req(REQ_READ, 30, 63, 1'b1));
        send_item(make_req(REQ_WRITE, 1, 1, 1'b1));
        send_item(make_req(REQ_WRITE, 62, 62, 1'b1));
        send_item(make_req(REQ_READ, 1, 1, 1'b0));
        send_item(make_req(REQ_READ, 62, 62, 1'b1));
        send_item(make_req(REQ_NONE, 63, 63, 1'b1));
        send_item(make_req(REQ_WRITE, 20, 19, 1'b1));
        send_item(make_req(REQ_WRITE, 20, 20, 1'b1));
        send_item(make_req(REQ_WRITE, 20, 21, 1'b1));
        send_item(make_req(REQ_STEP, 63, 63, 1'b1));
        send_item(make_req(REQ_READ, 19, 20, 1'b0));
        send_item(make_req(REQ_READ, 1, 1, 1'b1));
        send_item(make_req(REQ_STEP, 0, 0, 1'b0));
        send_item(make_req(REQ_READ, 20, 19, 1'b0));
        send_item(make_req(REQ_WRITE, 20, 20, 1'b0));
        send_item(make_req(REQ_READ, 20, 20, 1'b1));

        // Back-pressure: the receiver holds off while requests keep coming.
        hold_off_start = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(make_req(req_type_t'(i[0] ? REQ_READ : REQ_WRITE), $urandom_range(0, 63),
                               $urandom_range(0, 63), $urandom_range(0, 1)));

        send_idle_pct = 0;
        rsp_stall_pct = 0;
        random_phase(22);
        send_idle_pct = 73;
        random_phase(22);
        send_idle_pct = 0;
        rsp_stall_pct = 73;
        random_phase(22);
        send_idle_pct = 27;
        rsp_stall_pct = 27;
        random_phase(22);

        req_valid <= 1'b0;
        while (grid.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d cell writes, %0d reads and %0d unused request codes,",
                 grid.n_write, grid.n_read, grid.n_unused);
        $display("and %0d generations (%0d with changes); %0d responses checked.",
                 grid.n_step, grid.n_busy_step, grid.n_checked);
        if (grid.errors == 0)
            $display("life_grid_generation_engine: match");
        else
            $display("life_grid_generation_engine: mismatch");
        $finish;
    end

endmodule
